[rtl/lpc_pkg.sv]
`default_nettype none

package lpc_pkg;

    localparam int unsigned DIST_W  = 9;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned LED_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] RANGE_LOW_CM  = 9'd30;
    localparam logic [DIST_W-1:0] RANGE_HIGH_CM = 9'd380;
    localparam logic [LED_W-1:0]  LED_PWM_ON    = 8'd200;
    localparam logic [LED_W-1:0]  LED_PWM_OFF   = 8'd80;

    localparam logic [DIST_W-1:0]  RST_ON_DIST    = 9'd40;
    localparam logic [DIST_W-1:0]  RST_OFF_DIST   = 9'd100;
    localparam logic [DELAY_W-1:0] RST_ERR_DELAY  = 16'd5000;
    localparam logic [DELAY_W-1:0] RST_BLINK      = 16'd500;

    typedef logic [DIST_W-1:0] t_dist;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_DIST   = 3'd0,
        REG_OFF_DIST  = 3'd1,
        REG_ERR_DELAY = 3'd2,
        REG_BLINK     = 3'd3,
        REG_MANUAL    = 3'd4
    } t_reg_index;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_MANUAL = 1'b1
    } t_action;

    typedef enum logic {
        LED_PWM   = 1'b0,
        LED_BLINK = 1'b1
    } t_led_kind;

    typedef struct packed {
        logic              action;
        t_dist             distance;
        logic [TIME_W-1:0] now;
        logic              cmd;
    } t_request;

    typedef struct packed {
        t_dist            median;
        logic             pump;
        logic             error;
        logic             led_kind;
        logic [LED_W-1:0] led_value;
    } t_result;

endpackage

`default_nettype wire

[rtl/level_pump_controller.sv]
`default_nettype none

// Level pump controller with a median-filtered sonar distance.
// Input stream: tuser carries the request kind (sensor sample or manual
// pump command), tdata carries distance, millisecond time and the command.
// Output stream: one result per request with the filtered distance, pump
// drive, error flag and LED drive; tuser tells whether the LED value is a
// PWM duty or a blink pin level.
// A request is registered in the input register on acceptance and its
// result in the output register; the block takes one request every cycle
// while the receiver is ready. The median of the window comes from a
// rank-compare network over all window entries in the processing cycle.
// Configuration writes go through a separate channel that is always ready
// and should only be issued while no request is in flight.
// Reset restores the register defaults, clears the sample window and all
// control state, and empties both stages.
// When the receiver stalls, the result stays in the output register and the
// next request waits in the input register; the input side then stalls too.

module level_pump_controller #(
    parameter int WINDOW_SIZE = 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // distance_cm [8:0], now_ms [40:9], pump_command [41], zero fill
    input  wire logic [47:0]                      s_axis_tdata,
    // action
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // filtered_distance_cm [8:0], pump_on [9], error_state [10],
    // led_value [18:11], zero fill
    output logic [23:0]                           m_axis_tdata,
    // led_kind
    output logic                                  m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lpc_pkg::*;

    localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SIZE - 1);

    // Configuration registers.
    t_dist              r_on_dist;
    t_dist              r_off_dist;
    logic [DELAY_W-1:0] r_err_delay;
    logic [DELAY_W-1:0] r_blink_int;
    logic               r_manual;

    // Pipeline registers.
    t_request r_in;
    logic     r_in_valid;
    t_result  r_out;
    logic     r_out_valid;

    // Controller state.
    t_dist             r_window [WINDOW_SIZE];
    logic [PTR_W-1:0]  r_ptr;
    t_dist             r_median;
    logic              r_pump;
    logic              r_pend;
    logic              r_conf;
    logic [TIME_W-1:0] r_err_start;
    logic [TIME_W-1:0] r_toggle_time;
    logic              r_blink;
    logic              r_led_kind;
    logic [LED_W-1:0]  r_led_value;

    t_dist             n_window [WINDOW_SIZE];
    logic [PTR_W-1:0]  n_ptr;
    t_dist             n_median;
    logic              n_pump;
    logic              n_pend;
    logic              n_conf;
    logic [TIME_W-1:0] n_err_start;
    logic [TIME_W-1:0] n_toggle_time;
    logic              n_blink;
    logic              n_led_kind;
    logic [LED_W-1:0]  n_led_value;

    logic              w_fire;
    logic              w_sample;
    t_dist             w_median;
    logic              w_out_range;
    logic [TIME_W-1:0] w_err_age;
    logic [TIME_W-1:0] w_toggle_age;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_dist   <= RST_ON_DIST;
            r_off_dist  <= RST_OFF_DIST;
            r_err_delay <= RST_ERR_DELAY;
            r_blink_int <= RST_BLINK;
            r_manual    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ON_DIST:   r_on_dist   <= i_cfg_data[DIST_W-1:0];
                REG_OFF_DIST:  r_off_dist  <= i_cfg_data[DIST_W-1:0];
                REG_ERR_DELAY: r_err_delay <= i_cfg_data[DELAY_W-1:0];
                REG_BLINK:     r_blink_int <= i_cfg_data[DELAY_W-1:0];
                REG_MANUAL:    r_manual    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_sample      = (r_in.action == ACT_SAMPLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action   <= s_axis_tuser;
            r_in.distance <= s_axis_tdata[8:0];
            r_in.now      <= s_axis_tdata[40:9];
            r_in.cmd      <= s_axis_tdata[41];
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            n_window[i] = r_window[i];
        end
        n_window[r_ptr] = r_in.distance;
        n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
    end

    lpc_median #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_median (
        .i_window(n_window),
        .o_median(w_median)
    );

    assign w_out_range  = (w_median < RANGE_LOW_CM) || (w_median > RANGE_HIGH_CM);
    assign w_err_age    = r_in.now - r_err_start;
    assign w_toggle_age = r_in.now - r_toggle_time;

    always_comb begin
        n_median      = r_median;
        n_pump        = r_pump;
        n_pend        = r_pend;
        n_conf        = r_conf;
        n_err_start   = r_err_start;
        n_toggle_time = r_toggle_time;
        n_blink       = r_blink;
        n_led_kind    = r_led_kind;
        n_led_value   = r_led_value;
        if (w_sample) begin
            n_median = w_median;
            if (!r_manual) begin
                if (w_out_range) begin
                    if (!r_pend) begin
                        n_pend      = 1'b1;
                        n_err_start = r_in.now;
                    end else if (!r_conf && (w_err_age > TIME_W'(r_err_delay))) begin
                        n_conf = 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                    n_conf = 1'b0;
                end
                if (n_conf) begin
                    n_pump = 1'b0;
                end else if ((w_median <= r_on_dist) && !r_pump) begin
                    n_pump = 1'b1;
                end else if ((w_median >= r_off_dist) && r_pump) begin
                    n_pump = 1'b0;
                end
            end else begin
                n_pend = 1'b0;
                n_conf = 1'b0;
            end
            if (n_conf) begin
                if (w_toggle_age > TIME_W'(r_blink_int)) begin
                    n_toggle_time = r_in.now;
                    n_blink       = !r_blink;
                end
                n_led_kind  = LED_BLINK;
                n_led_value = LED_W'(n_blink);
            end else begin
                n_led_kind  = LED_PWM;
                n_led_value = n_pump ? LED_PWM_ON : LED_PWM_OFF;
            end
        end else if (r_manual) begin
            n_pump = r_in.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_window[i] <= '0;
            end
            r_ptr         <= '0;
            r_median      <= '0;
            r_pump        <= 1'b0;
            r_pend        <= 1'b0;
            r_conf        <= 1'b0;
            r_err_start   <= '0;
            r_toggle_time <= '0;
            r_blink       <= 1'b0;
            r_led_kind    <= LED_PWM;
            r_led_value   <= '0;
        end else if (w_fire) begin
            if (w_sample) begin
                for (int i = 0; i < WINDOW_SIZE; i++) begin
                    r_window[i] <= n_window[i];
                end
                r_ptr <= n_ptr;
            end
            r_median      <= n_median;
            r_pump        <= n_pump;
            r_pend        <= n_pend;
            r_conf        <= n_conf;
            r_err_start   <= n_err_start;
            r_toggle_time <= n_toggle_time;
            r_blink       <= n_blink;
            r_led_kind    <= n_led_kind;
            r_led_value   <= n_led_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.median    <= n_median;
            r_out.pump      <= n_pump;
            r_out.error     <= n_conf;
            r_out.led_kind  <= n_led_kind;
            r_out.led_value <= n_led_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.led_value, r_out.error, r_out.pump, r_out.median};
    assign m_axis_tuser  = r_out.led_kind;

    // A confirmed error always comes with a pending error.
    a_conf_implies_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conf |-> r_pend)
        else $error("confirmed error without pending error");

    // A result that reports an error drives the LED as a blink.
    a_error_blinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10]) |-> (m_axis_tuser == LED_BLINK))
        else $error("error result without blink LED");

    // The window pointer stays inside the window.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("window pointer out of range");

endmodule

`default_nettype wire

[rtl/lpc_median.sv]
`default_nettype none

module lpc_median #(
    parameter int WINDOW_SIZE = 5
) (
    input  wire lpc_pkg::t_dist i_window [WINDOW_SIZE],
    output lpc_pkg::t_dist o_median
);
    import lpc_pkg::*;

    localparam int RANK_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [RANK_W-1:0] MID = RANK_W'(WINDOW_SIZE / 2);

    logic [RANK_W-1:0] w_rank [WINDOW_SIZE];

    // Each entry gets a unique rank; ties are broken by position.
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                if (j != i) begin
                    if ((i_window[j] < i_window[i]) ||
                        ((i_window[j] == i_window[i]) && (j < i))) begin
                        w_rank[i] = w_rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            if (w_rank[i] == MID) begin
                o_median = i_window[i];
            end
        end
    end

endmodule

`default_nettype wire

[tb/sv/level_pump_controller_test.sv]
`timescale 1ns / 100ps

module level_pump_controller_test;

    import lpc_pkg::*;

    localparam int WIN        = 5;
    localparam int IDLE_PCT   = 29;
    localparam int QUIET_MAX  = 2000;
    localparam int PRINT_MAX  = 100;
    localparam int DRAIN_WAIT = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted controller state and register copies.
    t_dist                 level_window [WIN];
    int                    level_wptr;
    t_dist                 level_median;
    logic                  pump_level;
    logic                  err_pending;
    logic                  err_confirmed;
    logic [TIME_W-1:0]     err_since;
    logic [TIME_W-1:0]     blink_since;
    logic                  blink_pin;
    logic                  led_kind_out;
    logic [LED_W-1:0]      led_value_out;
    t_dist                 on_cm;
    t_dist                 off_cm;
    logic [DELAY_W-1:0]    err_delay;
    logic [DELAY_W-1:0]    blink_ms;
    logic                  manual_on;

    t_result               expected_results [$];
    int                    fail_count;
    int                    quiet_cycles;
    logic                  calm;

    level_pump_controller #(
        .WINDOW_SIZE(WIN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_controller();
        for (int i = 0; i < WIN; i++) begin
            level_window[i] = '0;
        end
        level_wptr    = 0;
        level_median  = '0;
        pump_level    = 1'b0;
        err_pending   = 1'b0;
        err_confirmed = 1'b0;
        err_since     = '0;
        blink_since   = '0;
        blink_pin     = 1'b0;
        led_kind_out  = LED_PWM;
        led_value_out = '0;
        on_cm         = RST_ON_DIST;
        off_cm        = RST_OFF_DIST;
        err_delay     = RST_ERR_DELAY;
        blink_ms      = RST_BLINK;
        manual_on     = 1'b0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ON_DIST:   on_cm = data[DIST_W-1:0];
            REG_OFF_DIST:  off_cm = data[DIST_W-1:0];
            REG_ERR_DELAY: err_delay = data[DELAY_W-1:0];
            REG_BLINK:     blink_ms = data[DELAY_W-1:0];
            REG_MANUAL:    manual_on = data[0];
            default: ;
        endcase
    endfunction

    function automatic t_result predict_level(logic act, t_dist dist_cm,
                                              logic [TIME_W-1:0] now, logic cmd);
        t_dist             sorted [WIN];
        t_dist             v;
        int                i;
        int                j;
        logic              out_of_range;
        logic [TIME_W-1:0] elapsed;
        t_result           r;
        if (act == ACT_SAMPLE) begin
            level_window[level_wptr] = dist_cm;
            level_wptr = (level_wptr + 1 >= WIN) ? 0 : level_wptr + 1;
            for (i = 0; i < WIN; i++) begin
                sorted[i] = level_window[i];
            end
            for (i = 1; i < WIN; i++) begin
                v = sorted[i];
                j = i - 1;
                while (j >= 0 && sorted[j] > v) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = v;
            end
            level_median = sorted[WIN / 2];
            out_of_range = (level_median < RANGE_LOW_CM) || (level_median > RANGE_HIGH_CM);
            if (!manual_on) begin
                if (out_of_range) begin
                    elapsed = now - err_since;
                    if (!err_pending) begin
                        err_pending = 1'b1;
                        err_since   = now;
                    end else if (!err_confirmed && elapsed > TIME_W'(err_delay)) begin
                        err_confirmed = 1'b1;
                    end
                end else begin
                    err_pending   = 1'b0;
                    err_confirmed = 1'b0;
                end
                if (err_confirmed) begin
                    pump_level = 1'b0;
                end else if (level_median <= on_cm && !pump_level) begin
                    pump_level = 1'b1;
                end else if (level_median >= off_cm && pump_level) begin
                    pump_level = 1'b0;
                end
            end else begin
                err_pending   = 1'b0;
                err_confirmed = 1'b0;
            end
            if (err_confirmed) begin
                elapsed = now - blink_since;
                if (elapsed > TIME_W'(blink_ms)) begin
                    blink_since = now;
                    blink_pin   = ~blink_pin;
                end
                led_kind_out  = LED_BLINK;
                led_value_out = LED_W'(blink_pin);
            end else begin
                led_kind_out  = LED_PWM;
                led_value_out = pump_level ? LED_PWM_ON : LED_PWM_OFF;
            end
        end else if (manual_on) begin
            pump_level = cmd;
        end
        r.median    = level_median;
        r.pump      = pump_level;
        r.error     = err_confirmed;
        r.led_kind  = led_kind_out;
        r.led_value = led_value_out;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_MAX) begin
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request pending", 32'(m_axis_tdata), 32'd0);
        end else begin
            want = expected_results.pop_front();
            if (m_axis_tdata[8:0] !== want.median) begin
                report_mismatch("filtered distance", 32'(m_axis_tdata[8:0]),
                                32'(want.median));
            end
            if (m_axis_tdata[9] !== want.pump) begin
                report_mismatch("pump drive", 32'(m_axis_tdata[9]), 32'(want.pump));
            end
            if (m_axis_tdata[10] !== want.error) begin
                report_mismatch("error flag", 32'(m_axis_tdata[10]), 32'(want.error));
            end
            if (m_axis_tuser !== want.led_kind) begin
                report_mismatch("led kind", 32'(m_axis_tuser), 32'(want.led_kind));
            end
            if (m_axis_tdata[18:11] !== want.led_value) begin
                report_mismatch("led value", 32'(m_axis_tdata[18:11]),
                                32'(want.led_value));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_level(s_axis_tuser, s_axis_tdata[8:0],
                                                         s_axis_tdata[40:9],
                                                         s_axis_tdata[41]));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("level_pump_controller: mismatch");
            $finish;
        end
    end

    task automatic send_request(t_action act, t_dist dist_cm, logic [TIME_W-1:0] now,
                                logic cmd);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'b0, cmd, now, dist_cm};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // The window starts cleared, so the first medians read zero; a raw value
    // above 400 is stored as it is.
    task automatic test_startup_window();
        send_request(ACT_SAMPLE, 9'd100, 32'd0, 1'b0);
        send_request(ACT_SAMPLE, 9'd200, 32'd10, 1'b0);
        send_request(ACT_SAMPLE, 9'd300, 32'd20, 1'b0);
        send_request(ACT_SAMPLE, 9'd400, 32'd30, 1'b0);
        send_request(ACT_SAMPLE, 9'd511, 32'd40, 1'b0);
        send_request(ACT_MANUAL, 9'd0, 32'd50, 1'b1);
        wait_idle();
    endtask

    // Error confirmation and blinking across a wrap of the millisecond time.
    task automatic test_error_timing();
        write_reg(REG_ERR_DELAY, 16'd0);
        write_reg(REG_BLINK, 16'd0);
        send_request(ACT_SAMPLE, 9'd0, 32'hFFFF_FFF0, 1'b0);
        send_request(ACT_SAMPLE, 9'd0, 32'hFFFF_FFF8, 1'b0);
        send_request(ACT_SAMPLE, 9'd0, 32'h0000_0004, 1'b0);
        send_request(ACT_SAMPLE, 9'd0, 32'h0000_0010, 1'b0);
        send_request(ACT_SAMPLE, 9'd0, 32'h0000_0020, 1'b0);
        wait_idle();
        write_reg(REG_ERR_DELAY, 16'hFFFF);
        write_reg(REG_BLINK, 16'hFFFF);
        send_request(ACT_SAMPLE, 9'd401, 32'h0000_0040, 1'b0);
        send_request(ACT_SAMPLE, 9'd381, 32'h0001_0100, 1'b0);
        send_request(ACT_SAMPLE, 9'd200, 32'h0001_0200, 1'b0);
        send_request(ACT_SAMPLE, 9'd29, 32'h0001_0300, 1'b0);
        wait_idle();
    endtask

    task automatic test_hysteresis();
        write_reg(REG_ON_DIST, 16'hFFFF);
        write_reg(REG_OFF_DIST, 16'd0);
        send_request(ACT_SAMPLE, 9'd35, 32'h0002_0000, 1'b0);
        send_request(ACT_SAMPLE, 9'd35, 32'h0002_0010, 1'b0);
        wait_idle();
        write_reg(REG_ON_DIST, 16'd0);
        write_reg(REG_OFF_DIST, 16'd400);
        send_request(ACT_SAMPLE, 9'd380, 32'h0002_0020, 1'b0);
        send_request(ACT_SAMPLE, 9'd30, 32'h0002_0030, 1'b0);
        wait_idle();
    endtask

    // Manual mode clears the error, leaves the pump alone on a sample and
    // takes the pump from a command request.
    task automatic test_manual_mode();
        write_reg(REG_MANUAL, 16'd1);
        send_request(ACT_SAMPLE, 9'd0, 32'h0003_0000, 1'b0);
        send_request(ACT_MANUAL, 9'd400, 32'h0003_0010, 1'b1);
        send_request(ACT_MANUAL, 9'd0, 32'h0003_0020, 1'b0);
        send_request(ACT_MANUAL, 9'd511, 32'h0003_0030, 1'b1);
        wait_idle();
        write_reg(REG_MANUAL, 16'd0);
        send_request(ACT_SAMPLE, 9'd200, 32'h0003_0040, 1'b0);
        wait_idle();
    endtask

    task automatic test_unknown_index();
        int idx;
        for (idx = int'(REG_MANUAL) + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(CFG_IDX_W'(idx), 16'hFFFF);
        end
        send_request(ACT_SAMPLE, 9'd150, 32'h0004_0000, 1'b0);
        wait_idle();
    endtask

    // Each phase picks a register setting and then streams a wandering water
    // level with bursts of lost echoes, noise spikes and command requests.
    task automatic test_random_phases();
        int                  phase;
        int                  level;
        int                  burst;
        logic [TIME_W-1:0]   now;
        t_dist               dist_cm;
        logic [CFG_DATA_W-1:0] on_val;
        logic [CFG_DATA_W-1:0] off_val;
        logic [CFG_DATA_W-1:0] delay_val;
        logic [CFG_DATA_W-1:0] blink_val;
        logic [CFG_DATA_W-1:0] mode_val;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    on_val = '0; off_val = '0; delay_val = '0; blink_val = '0;
                    mode_val = '0;
                end
                1: begin
                    on_val = '1; off_val = '1; delay_val = '1; blink_val = '1;
                    mode_val = '1;
                end
                default: begin
                    on_val    = CFG_DATA_W'($urandom_range(30, 200));
                    off_val   = CFG_DATA_W'(on_val + $urandom_range(0, 150));
                    delay_val = CFG_DATA_W'($urandom_range(0, 4000));
                    blink_val = CFG_DATA_W'($urandom_range(0, 1000));
                    mode_val  = (phase == 3) ? 16'd1 : 16'd0;
                end
            endcase
            write_reg(REG_ON_DIST, on_val);
            write_reg(REG_OFF_DIST, off_val);
            write_reg(REG_ERR_DELAY, delay_val);
            write_reg(REG_BLINK, blink_val);
            write_reg(REG_MANUAL, mode_val);
            calm  = (phase == 2);
            level = $urandom_range(30, 380);
            burst = 0;
            now   = $urandom;
            repeat (250) begin
                if ($urandom_range(99) < 15) begin
                    send_request(ACT_MANUAL, t_dist'($urandom), now,
                                 1'($urandom_range(1)));
                end else begin
                    if (burst == 0 && $urandom_range(99) < 3) begin
                        burst = $urandom_range(3, 40);
                    end
                    level = level + int'($urandom_range(0, 40)) - 20;
                    if (level < 30) level = 30;
                    if (level > 380) level = 380;
                    if (burst > 0) begin
                        burst--;
                        dist_cm = $urandom_range(1) ? t_dist'($urandom_range(0, 29))
                                                    : t_dist'($urandom_range(381, 511));
                    end else if ($urandom_range(99) < 5) begin
                        dist_cm = t_dist'($urandom_range(0, 511));
                    end else begin
                        dist_cm = t_dist'(level);
                    end
                    send_request(ACT_SAMPLE, dist_cm, now, 1'($urandom_range(1)));
                end
                if ($urandom_range(99) < 2) begin
                    now = $urandom;
                end else begin
                    now = now + $urandom_range(0, 400);
                end
            end
            wait_idle();
        end
        calm = 1'b0;
    endtask

    initial begin
        clear_controller();
        fail_count    = 0;
        quiet_cycles  = 0;
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_startup_window();
        test_error_timing();
        test_hysteresis();
        test_manual_mode();
        test_unknown_index();
        test_random_phases();
        if (fail_count == 0) begin
            $display("level_pump_controller: match");
        end else begin
            $display("level_pump_controller: mismatch");
        end
        $finish;
    end

endmodule
